/* rtl/gss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gillespie step package
// Constants, reaction tables, status codes and sequencer states shared by the
// stochastic step block and its checker.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int NUM_REACTIONS = 22;
    localparam int NUM_SPECIES   = 6;
    localparam int NUM_REGS      = 7;
    localparam int IDX_BITS      = 5;
    localparam int PROP_BITS     = 56;
    localparam int TOTAL_BITS    = 61;
    localparam int TIME_BITS     = 48;
    localparam int NUM_BITS      = 38;
    localparam int LOG_FRAC      = 24;

    localparam logic [31:0] CNT_MAX  = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    typedef logic [2:0] t_code3;
    typedef logic [1:0] t_ninv;

    localparam t_code3 ONE_IDX     = 3'd6;
    localparam t_code3 REG_INV_CAP = 3'd6;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ST_FIRED  = 2'd0,
        ST_NONE   = 2'd1,
        ST_LOADED = 2'd2
    } t_status;

    localparam t_code3 RX_RATE [NUM_REACTIONS] = '{
        3'd0, 3'd0, 3'd0, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd4, 3'd2, 3'd1,
        3'd1, 3'd1, 3'd3, 3'd1, 3'd1, 3'd1, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5};
    localparam t_code3 RX_F1 [NUM_REACTIONS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd0,
        3'd0, 3'd0, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd0, 3'd4, 3'd1, 3'd5};
    localparam t_code3 RX_F2 [NUM_REACTIONS] = '{
        3'd2, 3'd0, 3'd1, 3'd3, 3'd6, 3'd2, 3'd1, 3'd1, 3'd3, 3'd6, 3'd6,
        3'd2, 3'd3, 3'd6, 3'd6, 3'd2, 3'd3, 3'd6, 3'd3, 3'd6, 3'd3, 3'd6};
    localparam t_code3 RX_F3 [NUM_REACTIONS] = '{
        3'd6, 3'd2, 3'd2, 3'd6, 3'd6, 3'd6, 3'd2, 3'd2, 3'd6, 3'd6, 3'd6,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};
    localparam t_ninv RX_NINV [NUM_REACTIONS] = '{
        2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0};
    localparam t_code3 RX_TGT [NUM_REACTIONS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5};
    localparam logic RX_UP [NUM_REACTIONS] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    typedef enum logic [4:0] {
        S_IDLE,
        S_PROP_START,
        S_PROP_OP,
        S_PMUL_HI,
        S_PMUL_FIX,
        S_PROP_STORE,
        S_PICK_LO,
        S_PICK_HI,
        S_PICK_FIX,
        S_SEL_ADD,
        S_SEL_CMP,
        S_TAU,
        S_NORM,
        S_SQ,
        S_SQ_FIX,
        S_LN,
        S_LN_FIX,
        S_DIV,
        S_TIME,
        S_DONE
    } t_state;

endpackage

/* rtl/gillespie_ssa_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gillespie direct-method step
// Six-species, 22-reaction stochastic step built round one shared 32x32
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage. Rate constants and the reciprocal capacity are written through the
// configuration channel (index 0..6); the user must write them only while
// the block is idle, as the block itself does not enforce it. Ready is always
// high. An item is transferred on the input channel when i_in_valid is high
// and o_in_stall is low. A load item (cmd high) sets one species count and
// clears time; it goes through the final state to the output register. A step
// item walks all 22 propensities through the multiplier, skipping unused
// factors, scans the cumulative sums, normalises r1 one bit a cycle, squares
// 24 times for the logarithm and divides one quotient bit a cycle, 38 bits in
// all. A zero pick number or total skips the scan; a zero tau number or total
// sets time to its maximum without the logarithm. o_in_stall stays high for
// the whole step. The result sits in an output register until transferred;
// while the receiver stalls, the next item may still be taken and worked on,
// and it waits in its final state until the register is free. Synchronous
// reset clears the counts, time, registers and both channels.
// ----------------------------------------------------------------------------
module gillespie_ssa_step import gss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_rand_tau,
    input  logic [31:0] i_rand_pick,
    input  logic [2:0]  i_species_sel,
    input  logic [15:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_reaction,
    output logic [1:0]  o_status,
    output logic [47:0] o_time_now,
    output logic [15:0] o_count_r1,
    output logic [15:0] o_count_r2,
    output logic [15:0] o_count_replicase,
    output logic [15:0] o_count_coat,
    output logic [15:0] o_count_virion1,
    output logic [15:0] o_count_virion2
);

    localparam logic [IDX_BITS-1:0] LAST_RX  = IDX_BITS'(NUM_REACTIONS - 1);
    localparam logic [4:0]          LAST_SQ  = 5'(LOG_FRAC - 1);
    localparam logic [5:0]          LAST_BIT = 6'(NUM_BITS - 1);

    t_state r_state, n_state;

    // Architectural state.
    logic [31:0]            r_cfg [NUM_REGS];
    logic [COUNT_BITS-1:0]  r_cnt [NUM_SPECIES];
    logic [TIME_BITS-1:0]   r_time;

    // Working registers of the sequencer.
    logic [31:0]            r_rand_tau, r_rand_pick;
    logic [IDX_BITS-1:0]    r_idx;
    logic [2:0]             r_op;
    logic [63:0]            r_t, r_plo, r_prod;
    logic [PROP_BITS-1:0]   r_w [NUM_REACTIONS];
    logic [TOTAL_BITS-1:0]  r_total, r_part, r_rem;
    logic [TOTAL_BITS:0]    r_lc;
    logic [31:0]            r_m;
    logic [4:0]             r_shift, r_iter;
    logic [LOG_FRAC-1:0]    r_frac;
    logic [NUM_BITS-1:0]    r_num;
    logic [5:0]             r_bit;
    logic [4:0]             r_rx;
    t_status                r_status;

    // Output register.
    logic                   r_out_valid;
    logic [4:0]             r_o_reaction;
    t_status                r_o_status;
    logic [TIME_BITS-1:0]   r_o_time;
    logic [15:0]            r_o_cnt [NUM_SPECIES];

    // Shared multiplier operands.
    logic [31:0]            mul_a, mul_b;

    logic                   in_xfer, can_load;
    t_code3                 fidx;
    logic                   op_active, op_sh32;
    logic [31:0]            operand;
    logic [64:0]            mid;
    logic [63:0]            prod_next;
    logic [PROP_BITS-1:0]   w_clamp;
    logic [TOTAL_BITS:0]    lc_next;
    logic                   fire, pick_skip, tau_sat;
    logic [32:0]            sq;
    logic [29:0]            ln_arg;
    logic [TOTAL_BITS:0]    trial, diff;
    logic                   ge;
    logic [TIME_BITS-1:0]   tau_ext;
    logic                   time_sat;
    logic [31:0]            load_ext;
    logic [COUNT_BITS-1:0]  load_cnt;
    t_code3                 tgt;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign can_load  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Operand of the current propensity product: a count, one, or the
    // reciprocal capacity for the one or two scaling steps.
    always_comb begin
        fidx      = ONE_IDX;
        op_active = 1'b0;
        op_sh32   = 1'b0;
        operand   = r_cfg[REG_INV_CAP];
        case (r_op)
            3'd0:    fidx = RX_F1[r_idx];
            3'd1:    fidx = RX_F2[r_idx];
            3'd2:    fidx = RX_F3[r_idx];
            default: fidx = ONE_IDX;
        endcase
        if (r_op < 3'd3) begin
            op_active = (fidx != ONE_IDX);
            operand   = (fidx < t_code3'(NUM_SPECIES)) ? 32'(r_cnt[fidx]) : 32'd1;
        end else begin
            op_sh32   = 1'b1;
            op_active = (r_op == 3'd3) ? (RX_NINV[r_idx] >= 2'd1)
                                       : (RX_NINV[r_idx] >= 2'd2);
        end
    end

    // Recombine the two 32-bit partial products.
    assign mid = {1'b0, r_prod} + {33'b0, r_plo[63:32]};
    assign prod_next = op_sh32 ? mid[63:0]
                     : ((mid[64:32] != 33'b0) ? '1 : {mid[31:0], r_plo[31:0]});
    assign w_clamp = (r_t[63:PROP_BITS] != '0) ? '1 : r_t[PROP_BITS-1:0];

    // Rounded-up high part of r2 times the total, so that the comparison
    // against a partial sum needs no low word.
    assign lc_next = {1'b0, mid[TOTAL_BITS-1:0]}
                   + {{TOTAL_BITS{1'b0}}, (r_plo[31:0] != 32'b0)};
    assign fire      = (r_lc <= {1'b0, r_part});
    assign pick_skip = (r_total == '0) || (r_rand_pick == 32'b0);
    assign tau_sat   = (r_total == '0) || (r_rand_tau == 32'b0);

    assign sq     = r_prod[63:31];
    assign ln_arg = {6'(r_shift) + 6'd1, 24'b0} - {6'b0, r_frac};

    assign trial = {r_rem, r_num[NUM_BITS-1]};
    assign ge    = (trial >= {1'b0, r_total});
    assign diff  = trial - {1'b0, r_total};

    assign tau_ext  = TIME_BITS'(r_num);
    assign time_sat = (tau_ext >= ~r_time);

    assign load_ext = 32'(i_load_value);
    assign load_cnt = COUNT_BITS'((load_ext > CNT_MAX) ? CNT_MAX : load_ext);
    assign tgt      = RX_TGT[r_idx];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_cmd == CMD_LOAD) ? S_DONE : S_PROP_START;
                end
            end
            S_PROP_START: n_state = S_PROP_OP;
            S_PROP_OP: begin
                if (op_active) begin
                    n_state = S_PMUL_HI;
                end else if (r_op == 3'd4) begin
                    n_state = S_PROP_STORE;
                end
            end
            S_PMUL_HI:  n_state = S_PMUL_FIX;
            S_PMUL_FIX: n_state = (r_op == 3'd4) ? S_PROP_STORE : S_PROP_OP;
            S_PROP_STORE: n_state = (r_idx == LAST_RX) ? S_PICK_LO : S_PROP_START;
            S_PICK_LO:  n_state = pick_skip ? S_TAU : S_PICK_HI;
            S_PICK_HI:  n_state = S_PICK_FIX;
            S_PICK_FIX: n_state = S_SEL_ADD;
            S_SEL_ADD:  n_state = S_SEL_CMP;
            S_SEL_CMP:  n_state = (fire || r_idx == LAST_RX) ? S_TAU : S_SEL_ADD;
            S_TAU:      n_state = tau_sat ? S_DONE : S_NORM;
            S_NORM:     n_state = r_m[31] ? S_SQ : S_NORM;
            S_SQ:       n_state = S_SQ_FIX;
            S_SQ_FIX:   n_state = (r_iter == LAST_SQ) ? S_LN : S_SQ;
            S_LN:       n_state = S_LN_FIX;
            S_LN_FIX:   n_state = S_DIV;
            S_DIV:      n_state = (r_bit == 6'd0) ? S_TIME : S_DIV;
            S_TIME:     n_state = S_DONE;
            S_DONE:     n_state = can_load ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operand selection and input stall.
    always_comb begin
        mul_a      = 32'b0;
        mul_b      = 32'b0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_PROP_OP: begin
                mul_a = r_t[31:0];
                mul_b = operand;
            end
            S_PMUL_HI: begin
                mul_a = r_t[63:32];
                mul_b = operand;
            end
            S_PICK_LO: begin
                mul_a = r_rand_pick;
                mul_b = r_total[31:0];
            end
            S_PICK_HI: begin
                mul_a = r_rand_pick;
                mul_b = 32'(r_total[TOTAL_BITS-1:32]);
            end
            S_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            S_LN: begin
                mul_a = {2'b0, ln_arg};
                mul_b = LN2_Q32;
            end
            default: begin
                mul_a = 32'b0;
                mul_b = 32'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // State, counts, time, registers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_time      <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= 32'b0;
            end
            for (int i = 0; i < NUM_SPECIES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < 3'(NUM_REGS)) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            if (r_state == S_IDLE && in_xfer && i_cmd == CMD_LOAD) begin
                r_time <= '0;
                if (i_species_sel < 3'(NUM_SPECIES)) begin
                    r_cnt[i_species_sel] <= load_cnt;
                end
            end
            if (r_state == S_SEL_CMP && fire) begin
                if (RX_UP[r_idx]) begin
                    if (r_cnt[tgt] != '1) begin
                        r_cnt[tgt] <= r_cnt[tgt] + 1'b1;
                    end
                end else if (r_cnt[tgt] != '0) begin
                    r_cnt[tgt] <= r_cnt[tgt] - 1'b1;
                end
            end
            if (r_state == S_TAU && tau_sat) begin
                r_time <= '1;
            end
            if (r_state == S_TIME) begin
                r_time <= time_sat ? '1 : r_time + tau_ext;
            end
            if (r_state == S_DONE && can_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rand_tau  <= i_rand_tau;
                r_rand_pick <= i_rand_pick;
                r_idx       <= '0;
                r_total     <= '0;
                r_rx        <= 5'd0;
                r_status    <= (i_cmd == CMD_LOAD) ? ST_LOADED : ST_NONE;
            end
            S_PROP_START: begin
                r_t  <= 64'(r_cfg[RX_RATE[r_idx]]);
                r_op <= 3'd0;
            end
            S_PROP_OP: begin
                if (!op_active) begin
                    r_op <= r_op + 3'd1;
                end
            end
            S_PMUL_HI: r_plo <= r_prod;
            S_PMUL_FIX: begin
                r_t  <= prod_next;
                r_op <= r_op + 3'd1;
            end
            S_PROP_STORE: begin
                r_w[r_idx] <= w_clamp;
                r_total    <= r_total + TOTAL_BITS'(w_clamp);
                r_idx      <= r_idx + 1'b1;
            end
            S_PICK_HI: r_plo <= r_prod;
            S_PICK_FIX: begin
                r_lc   <= lc_next;
                r_idx  <= '0;
                r_part <= '0;
            end
            S_SEL_ADD: r_part <= r_part + TOTAL_BITS'(r_w[r_idx]);
            S_SEL_CMP: begin
                if (fire) begin
                    r_rx     <= 5'(r_idx) + 5'd1;
                    r_status <= ST_FIRED;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_TAU: begin
                r_m     <= r_rand_tau;
                r_shift <= 5'd0;
            end
            S_NORM: begin
                if (r_m[31]) begin
                    r_iter <= 5'd0;
                    r_frac <= '0;
                end else begin
                    r_m     <= {r_m[30:0], 1'b0};
                    r_shift <= r_shift + 5'd1;
                end
            end
            S_SQ_FIX: begin
                // Squaring past two means one more fraction bit of the log.
                r_m    <= sq[32] ? sq[32:1] : sq[31:0];
                r_frac <= {r_frac[LOG_FRAC-2:0], sq[32]};
                r_iter <= r_iter + 5'd1;
            end
            S_LN_FIX: begin
                r_num <= r_prod[NUM_BITS+LOG_FRAC-1:LOG_FRAC];
                r_rem <= '0;
                r_bit <= LAST_BIT;
            end
            S_DIV: begin
                r_rem <= ge ? diff[TOTAL_BITS-1:0] : trial[TOTAL_BITS-1:0];
                r_num <= {r_num[NUM_BITS-2:0], ge};
                r_bit <= r_bit - 6'd1;
            end
            default: begin
            end
        endcase
    end

    // Output register, loaded as the item leaves its final state.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && can_load) begin
            r_o_reaction <= r_rx;
            r_o_status   <= r_status;
            r_o_time     <= r_time;
            for (int i = 0; i < NUM_SPECIES; i++) begin
                r_o_cnt[i] <= 16'(r_cnt[i]);
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reaction        = r_o_reaction;
    assign o_status          = r_o_status;
    assign o_time_now        = r_o_time;
    assign o_count_r1        = r_o_cnt[0];
    assign o_count_r2        = r_o_cnt[1];
    assign o_count_replicase = r_o_cnt[2];
    assign o_count_coat      = r_o_cnt[3];
    assign o_count_virion1   = r_o_cnt[4];
    assign o_count_virion2   = r_o_cnt[5];

endmodule

/* rtl/gss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gillespie step checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gss_checker import gss_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [4:0]  o_reaction,
    input logic [1:0]  o_status,
    input logic [47:0] o_time_now
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_reaction)
            && $stable(o_status) && $stable(o_time_now))
        else $error("stalled result changed");

    // A load result carries no reaction and clears time.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_LOADED |-> o_reaction == 5'd0
            && o_time_now == 48'd0)
        else $error("load result malformed");

    // No reaction means reaction code zero.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NONE |-> o_reaction == 5'd0)
        else $error("idle step reports a reaction");

    // A fired reaction is one of the model's reactions.
    a_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FIRED |-> o_reaction != 5'd0
            && o_reaction <= 5'(NUM_REACTIONS))
        else $error("fired reaction out of range");

endmodule

bind gillespie_ssa_step gss_checker u_gss_checker (.*);
